// ===== hw/rtl/atep_pkg.sv =====
package atep_pkg;

    // asn.1 tags
    localparam logic [7:0] TAG_UTC = 8'd23;
    localparam logic [7:0] TAG_GEN = 8'd24;

    // ascii digit bounds
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int POS_W   = 4;
    localparam int TOD_W   = 19;
    localparam int DAYS_W  = 23;
    localparam int SECS_W  = 39;

    // string lengths
    localparam logic [POS_W-1:0] LEN_UTC = 4'd13;
    localparam logic [POS_W-1:0] LEN_GEN = 4'd15;

    // default depth of the record queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // one parsed time string, ready for the calendar math
    typedef struct packed {
        logic                ok;
        logic                utc;
        logic [YEAR_W-1:0]   year;
        logic [3:0]          month;
        logic [4:0]          day;
        logic [FIELD_W-1:0]  hour;
        logic [FIELD_W-1:0]  minute;
        logic [FIELD_W-1:0]  second;
    } atep_rec_t;

    // days before the first of a month, counted from march 1st
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] days;
        case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ===== hw/rtl/atep_front.sv =====
module atep_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            char_byte,
    input  logic [7:0]            time_tag,
    input  logic                  is_last,
    output atep_pkg::atep_rec_t   rec,
    output logic                  rec_push,
    input  logic                  rec_full
);
    import atep_pkg::*;

    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [7:0]         tag_reg;
    logic [YEAR_W-1:0]  year_reg,   year_next;
    logic [FIELD_W-1:0] month_reg,  month_next;
    logic [FIELD_W-1:0] day_reg,    day_next;
    logic [FIELD_W-1:0] hour_reg,   hour_next;
    logic [FIELD_W-1:0] minute_reg, minute_next;
    logic [FIELD_W-1:0] second_reg, second_next;
    logic               derr_reg,   derr_next;

    logic               xfer;
    logic [7:0]         tag_cur;
    logic               is_utc;
    logic               known;
    logic [POS_W-1:0]   ylen;
    logic [POS_W-1:0]   fdiff;
    logic               dig_pos;
    logic               is_dig;
    logic [3:0]         dig;
    logic [POS_W-1:0]   minlen;

    function automatic logic [YEAR_W-1:0] push_year(input logic [YEAR_W-1:0] acc,
                                                     input logic [3:0] d);
        return (acc << 3) + (acc << 1) + YEAR_W'(d);
    endfunction

    function automatic logic [FIELD_W-1:0] push_two(input logic [FIELD_W-1:0] acc,
                                                    input logic [3:0] d);
        return (acc << 3) + (acc << 1) + FIELD_W'(d);
    endfunction

    assign in_ready = !rec_full;
    assign xfer     = in_valid && in_ready;
    assign rec_push = xfer && is_last;

    // classify the character against the tag
    always_comb
    begin
        tag_cur = (pos_reg == '0) ? time_tag : tag_reg;
        is_utc  = (tag_cur == TAG_UTC);
        known   = is_utc || (tag_cur == TAG_GEN);
        ylen    = is_utc ? 4'd2 : 4'd4;
        fdiff   = pos_reg - ylen;
        dig_pos = known && (pos_reg < ylen + 4'd10);
        is_dig  = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
        dig     = is_dig ? 4'(char_byte - CHAR_ZERO) : 4'd0;
        minlen  = is_utc ? LEN_UTC : LEN_GEN;
    end

    // digit accumulation
    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        derr_next   = derr_reg;
        if (dig_pos)
        begin
            if (!is_dig)
            begin
                derr_next = 1'b1;
            end
            if (pos_reg < ylen)
            begin
                year_next = push_year(year_reg, dig);
            end
            else
            begin
                case (fdiff[3:1])
                    3'd0:    month_next  = push_two(month_reg, dig);
                    3'd1:    day_next    = push_two(day_reg, dig);
                    3'd2:    hour_next   = push_two(hour_reg, dig);
                    3'd3:    minute_next = push_two(minute_reg, dig);
                    default: second_next = push_two(second_reg, dig);
                endcase
            end
        end
        pos_next = (pos_reg == '1) ? pos_reg : pos_reg + 4'd1;
    end

    // record handed to the back end on the last character
    always_comb
    begin
        rec.ok     = known && (pos_next >= minlen) && !derr_next
                     && (month_next >= 7'd1) && (month_next <= 7'd12)
                     && (day_next >= 7'd1) && (day_next <= 7'd31);
        rec.utc    = is_utc;
        rec.year   = year_next;
        rec.month  = month_next[3:0];
        rec.day    = day_next[4:0];
        rec.hour   = hour_next;
        rec.minute = minute_next;
        rec.second = second_next;
    end

    // string state, cleared after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            tag_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            derr_reg   <= 1'b0;
        end
        else if (xfer)
        begin
            if (is_last)
            begin
                pos_reg    <= '0;
                tag_reg    <= '0;
                year_reg   <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                hour_reg   <= '0;
                minute_reg <= '0;
                second_reg <= '0;
                derr_reg   <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                tag_reg    <= tag_cur;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                derr_reg   <= derr_next;
            end
        end
    end

endmodule

// ===== hw/rtl/atep_fifo.sv =====
module atep_fifo #(
    parameter int DEPTH = atep_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  atep_pkg::atep_rec_t   din,
    output logic                  full,
    output logic                  valid,
    input  logic                  pop,
    output atep_pkg::atep_rec_t   dout
);
    import atep_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    atep_rec_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign dout    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== hw/rtl/atep_back.sv =====
module atep_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rec_valid,
    input  atep_pkg::atep_rec_t                 rec,
    output logic                                rec_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                time_valid,
    output logic signed [atep_pkg::SECS_W-1:0]  epoch_seconds
);
    import atep_pkg::*;

    localparam logic [YEAR_W-1:0]       UTC_PIVOT  = 14'd50;
    localparam logic [YEAR_W-1:0]       BASE_2000  = 14'd2000;
    localparam logic [YEAR_W-1:0]       BASE_1900  = 14'd1900;
    localparam logic [YEAR_W-1:0]       DIV400_K   = 14'd10486;
    localparam int                      DIV400_SH  = 22;
    localparam logic signed [15:0]      ERA_YEARS  = 16'sd400;
    localparam logic [17:0]             YEAR_DAYS  = 18'd365;
    localparam logic signed [DAYS_W-1:0] ERA_DAYS  = 23'sd146097;
    localparam logic signed [DAYS_W-1:0] EPOCH_OFS = 23'sd719468;
    localparam logic signed [SECS_W-1:0] DAY_SECS  = 39'sd86400;

    // pipeline enables, back to front
    logic en1, en2, en3, en4, en5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    // stage 1: year adjust, era, day of year, time of day
    logic [YEAR_W-1:0]         yfull;
    logic                      march;
    logic signed [YEAR_W:0]    yadj;
    logic [2*YEAR_W-1:0]       era_prod;
    logic signed [5:0]         era;
    logic [3:0]                mp;
    logic [8:0]                doy;
    logic [TOD_W-1:0]          tod;

    logic                      s1_ok_reg;
    logic signed [YEAR_W:0]    s1_yadj_reg;
    logic signed [5:0]         s1_era_reg;
    logic [8:0]                s1_doy_reg;
    logic [TOD_W-1:0]          s1_tod_reg;

    // stage 2: year of era
    logic signed [15:0]        yoe_full;
    logic                      s2_ok_reg;
    logic [8:0]                s2_yoe_reg;
    logic signed [5:0]         s2_era_reg;
    logic [8:0]                s2_doy_reg;
    logic [TOD_W-1:0]          s2_tod_reg;

    // stage 3: day of era and era base
    logic [1:0]                cent;
    logic [17:0]               doe;
    logic signed [DAYS_W-1:0]  eraday;
    logic                      s3_ok_reg;
    logic [17:0]               s3_doe_reg;
    logic signed [DAYS_W-1:0]  s3_eraday_reg;
    logic [TOD_W-1:0]          s3_tod_reg;

    // stage 4: days since epoch
    logic signed [DAYS_W-1:0]  days;
    logic                      s4_ok_reg;
    logic signed [DAYS_W-1:0]  s4_days_reg;
    logic [TOD_W-1:0]          s4_tod_reg;

    // output stage
    logic signed [SECS_W-1:0]  secs;
    logic                      time_valid_reg;
    logic signed [SECS_W-1:0]  epoch_seconds_reg;

    assign en5     = !out_valid_reg || out_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign rec_pop = rec_valid && en1;

    assign out_valid     = out_valid_reg;
    assign time_valid    = time_valid_reg;
    assign epoch_seconds = epoch_seconds_reg;

    always_comb
    begin
        if (rec.utc)
        begin
            yfull = (rec.year < UTC_PIVOT) ? rec.year + BASE_2000 : rec.year + BASE_1900;
        end
        else
        begin
            yfull = rec.year;
        end
        march    = (rec.month <= 4'd2);
        yadj     = $signed({1'b0, yfull}) - $signed({{YEAR_W{1'b0}}, march});
        era_prod = yadj[YEAR_W-1:0] * DIV400_K;
        era      = yadj[YEAR_W] ? -6'sd1 : $signed({1'b0, era_prod[DIV400_SH+4:DIV400_SH]});
        mp       = (rec.month > 4'd2) ? rec.month - 4'd3 : rec.month + 4'd9;
        doy      = month_offset(mp) + {4'b0, rec.day} - 9'd1;
        tod      = TOD_W'(rec.hour) * TOD_W'(3600) + TOD_W'(rec.minute) * TOD_W'(60)
                 + TOD_W'(rec.second);
    end

    always_comb
    begin
        yoe_full = 16'(s1_yadj_reg) - 16'(s1_era_reg) * ERA_YEARS;
    end

    always_comb
    begin
        if (s2_yoe_reg >= 9'd300)
        begin
            cent = 2'd3;
        end
        else if (s2_yoe_reg >= 9'd200)
        begin
            cent = 2'd2;
        end
        else if (s2_yoe_reg >= 9'd100)
        begin
            cent = 2'd1;
        end
        else
        begin
            cent = 2'd0;
        end
        doe    = 18'(s2_yoe_reg) * YEAR_DAYS + 18'(s2_yoe_reg[8:2]) - 18'(cent)
               + 18'(s2_doy_reg);
        eraday = DAYS_W'(s2_era_reg) * ERA_DAYS;
    end

    always_comb
    begin
        days = s3_eraday_reg + $signed({5'b0, s3_doe_reg}) - EPOCH_OFS;
    end

    always_comb
    begin
        secs = SECS_W'(s4_days_reg) * DAY_SECS + $signed({20'b0, s4_tod_reg});
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= rec_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ok_reg   <= rec.ok;
            s1_yadj_reg <= yadj;
            s1_era_reg  <= era;
            s1_doy_reg  <= doy;
            s1_tod_reg  <= tod;
        end
        if (en2)
        begin
            s2_ok_reg  <= s1_ok_reg;
            s2_yoe_reg <= yoe_full[8:0];
            s2_era_reg <= s1_era_reg;
            s2_doy_reg <= s1_doy_reg;
            s2_tod_reg <= s1_tod_reg;
        end
        if (en3)
        begin
            s3_ok_reg     <= s2_ok_reg;
            s3_doe_reg    <= doe;
            s3_eraday_reg <= eraday;
            s3_tod_reg    <= s2_tod_reg;
        end
        if (en4)
        begin
            s4_ok_reg   <= s3_ok_reg;
            s4_days_reg <= days;
            s4_tod_reg  <= s3_tod_reg;
        end
        if (en5)
        begin
            time_valid_reg    <= s4_ok_reg;
            epoch_seconds_reg <= s4_ok_reg ? secs : '0;
        end
    end

endmodule

// ===== hw/rtl/asn1_time_to_epoch_seconds.sv =====
// Certificate time string to Unix epoch seconds.
//
// Input channel (in_valid/in_ready): one ASCII character per transfer,
// with time_tag (23 UTCTime, 24 GeneralizedTime) taken on the first
// character of a string and is_last marking its final character.
// Output channel (out_valid/out_ready): one result per string, time_valid
// plus signed epoch_seconds (zero when the string did not convert).
//
// Throughput: one character per cycle while the queue is not full. The
// parser updates small digit accumulators on each transfer; a finished
// string is queued and the calendar arithmetic runs in a five-stage
// pipeline that takes a new string every cycle unless the output side
// stalls with the pipeline full. A finished record passes the queue
// entry, stages 1 to 4 and the output register before its result appears.
// Reset clears the parser, the queue and the pipeline; no result is
// pending afterwards. When the receiver stalls, the pipeline and then the
// queue fill; in_ready drops only once the queue is full.
module asn1_time_to_epoch_seconds #(
    parameter int QUEUE_DEPTH = atep_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          char_byte,
    input  logic [7:0]                          time_tag,
    input  logic                                is_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                time_valid,
    output logic signed [atep_pkg::SECS_W-1:0]  epoch_seconds
);
    import atep_pkg::*;

    atep_rec_t  push_rec;
    atep_rec_t  pop_rec;
    logic       rec_push;
    logic       rec_full;
    logic       rec_valid;
    logic       rec_pop;

    // character parser
    atep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .time_tag  (time_tag),
        .is_last   (is_last),
        .rec       (push_rec),
        .rec_push  (rec_push),
        .rec_full  (rec_full)
    );

    // record queue
    atep_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_push),
        .din   (push_rec),
        .full  (rec_full),
        .valid (rec_valid),
        .pop   (rec_pop),
        .dout  (pop_rec)
    );

    // calendar arithmetic
    atep_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (rec_valid),
        .rec           (pop_rec),
        .rec_pop       (rec_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .time_valid    (time_valid),
        .epoch_seconds (epoch_seconds)
    );

endmodule

// ===== hw/rtl/atep_chk.sv =====
module atep_chk (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [7:0]                          char_byte,
    input logic [7:0]                          time_tag,
    input logic                                is_last,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                time_valid,
    input logic signed [atep_pkg::SECS_W-1:0]  epoch_seconds
);
    import atep_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(time_valid)
                                   && $stable(epoch_seconds))
        else $error("result changed while stalled");

    // a stalled character holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_byte)
                                 && $stable(time_tag) && $stable(is_last))
        else $error("input changed while stalled");

    // failed conversions report zero seconds
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !time_valid |-> epoch_seconds == '0)
        else $error("invalid result with nonzero seconds");

    // converted times stay between year 0000 and the last day of 9999 plus at most 99:99:99
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && time_valid |-> (epoch_seconds >= -39'sd62167219200)
                                    && (epoch_seconds <= 39'sd253402576839))
        else $error("converted time out of range");

endmodule

bind asn1_time_to_epoch_seconds atep_chk u_atep_chk (.*);

// ===== tb/asn1_time_to_epoch_seconds_tb.sv =====
module asn1_time_to_epoch_seconds_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import atep_pkg::*;

    localparam logic [7:0] TAG_BOGUS   = 8'hFF;
    localparam int         RANDOM_CHARS = 1850;
    localparam int         CALM_CHARS   = 150;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         REROLL_CYCLES = 128;

    // one character transfer on the input side
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] tag;
        logic       last;
    } char_item_t;

    // converted time as the block should report it
    typedef struct {
        bit                        ok;
        logic signed [SECS_W-1:0]  secs;
    } time_result_t;

    // parser state kept alongside the block
    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [7:0]         tag;
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic               bad_digit;
    } time_parse_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [7:0]                 char_byte = 8'd0;
    logic [7:0]                 time_tag = 8'd0;
    logic                       is_last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       time_valid;
    logic signed [SECS_W-1:0]   epoch_seconds;

    char_item_t     pending_chars[$];
    time_result_t   expected_times[$];
    byte unsigned   text[$];
    time_parse_t    parser = '0;
    time_result_t   predicted;
    time_result_t   oldest;

    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;
    int  in_gap = 0;
    int  out_gap = 0;
    int  in_gap_pct = 0;
    int  out_gap_pct = 0;
    int  tick = 0;
    int  stall_cycles = 0;
    int  errors = 0;
    int  chars_sent = 0;
    int  times_checked = 0;
    int  times_valid = 0;
    int  times_invalid = 0;

    asn1_time_to_epoch_seconds DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_byte     (char_byte),
        .time_tag      (time_tag),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .time_valid    (time_valid),
        .epoch_seconds (epoch_seconds)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // proleptic gregorian day count relative to 1970-01-01, truncating division
    function automatic longint days_from_1970(longint y, longint m, longint d);
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        if (m <= 2)
            y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    // advance the parser by one character; returns 1 when a result is due
    function automatic bit parse_time_char(input logic [7:0] ch, input logic [7:0] tag_in,
                                           input logic last, output time_result_t res);
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] count;
        int               ylen;
        int               dig;
        int               f;
        bit               known;
        bit               ok;
        longint           y;
        longint           secs;
        p = parser.pos;
        if (p == 0)
            parser.tag = tag_in;
        known = (parser.tag == TAG_UTC) || (parser.tag == TAG_GEN);
        if (known)
        begin
            ylen = (parser.tag == TAG_UTC) ? 2 : 4;
            if (p < ylen + 10)
            begin
                dig = 0;
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                    dig = ch - CHAR_ZERO;
                else
                    parser.bad_digit = 1'b1;
                if (p < ylen)
                    parser.year = YEAR_W'(int'(parser.year) * 10 + dig);
                else
                begin
                    f = (p - ylen) >> 1;
                    case (f)
                        0: parser.month  = FIELD_W'(int'(parser.month) * 10 + dig);
                        1: parser.day    = FIELD_W'(int'(parser.day) * 10 + dig);
                        2: parser.hour   = FIELD_W'(int'(parser.hour) * 10 + dig);
                        3: parser.minute = FIELD_W'(int'(parser.minute) * 10 + dig);
                        default: parser.second = FIELD_W'(int'(parser.second) * 10 + dig);
                    endcase
                end
            end
        end
        count = (p < 15) ? POS_W'(p + 1) : POS_W'(15);
        parser.pos = count;
        if (!last)
            return 1'b0;

        // string complete: range checks, then calendar arithmetic
        ok = known;
        if (ok && count < ((parser.tag == TAG_UTC) ? LEN_UTC : LEN_GEN))
            ok = 1'b0;
        if (parser.bad_digit)
            ok = 1'b0;
        if (parser.month < 1 || parser.month > 12)
            ok = 1'b0;
        if (parser.day < 1 || parser.day > 31)
            ok = 1'b0;
        secs = 0;
        if (ok)
        begin
            y = longint'(parser.year);
            if (parser.tag == TAG_UTC)
                y = (y < 50) ? 2000 + y : 1900 + y;
            secs = days_from_1970(y, longint'(parser.month), longint'(parser.day)) * 86400
                 + longint'(parser.hour) * 3600 + longint'(parser.minute) * 60
                 + longint'(parser.second);
        end
        res.ok   = ok;
        res.secs = SECS_W'(secs);
        parser   = '0;
        return 1'b1;
    endfunction

    // queue the characters in text as one string; tag only matters on the first
    task automatic send_text(input logic [7:0] tag);
        char_item_t item;
        for (int i = 0; i < text.size(); i++)
        begin
            item.ch   = text[i];
            item.tag  = (i == 0) ? tag : 8'($urandom);
            item.last = (i == text.size() - 1);
            pending_chars.push_back(item);
        end
        text.delete();
    endtask

    task automatic send_str(input logic [7:0] tag, input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text(tag);
    endtask

    // append a zero padded decimal number
    task automatic put_num(input int v, input int digits);
        int div;
        div = 1;
        for (int i = 1; i < digits; i++)
            div = div * 10;
        for (int i = 0; i < digits; i++)
        begin
            text.push_back(8'(CHAR_ZERO + (v / div) % 10));
            div = div / 10;
        end
    endtask

    // well-formed time string in text; loose lets month and day stray out of range
    task automatic make_time(input bit gen, input bit loose);
        put_num(gen ? $urandom_range(0, 9999) : $urandom_range(0, 99), gen ? 4 : 2);
        put_num(loose ? $urandom_range(0, 99) : $urandom_range(1, 12), 2);
        put_num(loose ? $urandom_range(0, 99) : $urandom_range(1, 31), 2);
        put_num($urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
        put_num($urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
        put_num($urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
        text.push_back("Z");
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                text.push_back(8'($urandom));
    endtask

    // input side: hold until transfer, random idle bursts
    always @(negedge clk)
    begin
        tick++;
        if (tick % REROLL_CYCLES == 0)
        begin
            case ($urandom_range(0, 2))
                0: in_gap_pct = 0;
                1: in_gap_pct = 8;
                default: in_gap_pct = 30;
            endcase
        end
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
            ;
        else if (in_gap != 0)
        begin
            in_gap--;
            in_valid <= 1'b0;
        end
        else if (pending_chars.size() == 0)
            in_valid <= 1'b0;
        else if (pending_chars.size() > CALM_CHARS && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_gap = $urandom_range(0, 9);
            in_valid <= 1'b0;
        end
        else
        begin
            {char_byte, time_tag, is_last} <= pending_chars.pop_front();
            in_valid <= 1'b1;
        end
    end

    // output side: random stall bursts
    always @(negedge clk)
    begin
        if (tick % REROLL_CYCLES == 0)
        begin
            case ($urandom_range(0, 2))
                0: out_gap_pct = 0;
                1: out_gap_pct = 10;
                default: out_gap_pct = 35;
            endcase
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_gap != 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else if (pending_chars.size() > CALM_CHARS && $urandom_range(0, 99) < out_gap_pct)
        begin
            out_gap = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // sample transfers, check results, predict new ones, watchdog
    always @(posedge clk)
    begin
        in_fire  = rst_n && in_valid && in_ready;
        out_fire = rst_n && out_valid && out_ready;
        if (out_fire)
        begin
            if (expected_times.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result time_valid=%0b epoch_seconds=%0d",
                         $time, time_valid, epoch_seconds);
            end
            else
            begin
                oldest = expected_times.pop_front();
                times_checked++;
                if (time_valid !== oldest.ok)
                begin
                    errors++;
                    $display("%0t: time_valid mismatch expected %0b actual %0b",
                             $time, oldest.ok, time_valid);
                end
                if (epoch_seconds !== oldest.secs)
                begin
                    errors++;
                    $display("%0t: epoch_seconds mismatch expected %0d actual %0d",
                             $time, oldest.secs, epoch_seconds);
                end
            end
        end
        if (in_fire)
        begin
            chars_sent++;
            if (parse_time_char(char_byte, time_tag, is_last, predicted))
            begin
                expected_times.push_back(predicted);
                if (predicted.ok)
                    times_valid++;
                else
                    times_invalid++;
            end
        end
        if (!rst_n || in_fire || out_fire)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_times.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int r;
        int k;

        // directed strings: year pivots, extremes, each error kind, carry and trailing
        send_str(TAG_UTC, "000101000000Z");
        send_str(TAG_UTC, "491231235959Z");
        send_str(TAG_UTC, "500101000000Z");
        send_str(TAG_UTC, "991231235959Z");
        send_str(TAG_GEN, "00000101000000Z");
        send_str(TAG_GEN, "99991231999999Z");
        send_str(TAG_GEN, "19700101000000Z");
        send_str(TAG_GEN, "20000229000000Z");
        send_str(TAG_GEN, "19000301000000Z");
        send_str(TAG_BOGUS, "240101000000Z");
        send_str(TAG_UTC, "2401011200");
        send_str(TAG_GEN, "20240101000000");
        send_str(TAG_UTC, "24a101000000Z");
        send_str(TAG_UTC, "240001000000Z");
        send_str(TAG_UTC, "241301000000Z");
        send_str(TAG_UTC, "240100000000Z");
        send_str(TAG_UTC, "240132000000Z");
        send_str(TAG_UTC, "240231000000Z");
        send_str(TAG_GEN, "20240229123456Zxyz!");
        send_str(TAG_UTC, "7");

        // random strings, mostly well formed with random content
        while (pending_chars.size() < RANDOM_CHARS)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                make_time($urandom_range(0, 1), 1'b0);
                send_text(text.size() > 14 && text[14] == "Z" ? TAG_GEN : TAG_UTC);
            end
            else if (r < 72)
            begin
                k = $urandom_range(0, 1);
                make_time(k, 1'b1);
                send_text(k ? TAG_GEN : TAG_UTC);
            end
            else if (r < 82)
            begin
                // one corrupted character
                k = $urandom_range(0, 1);
                make_time(k, 1'b0);
                text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
                send_text(k ? TAG_GEN : TAG_UTC);
            end
            else if (r < 92)
            begin
                // cut short
                k = $urandom_range(0, 1);
                make_time(k, 1'b0);
                r = $urandom_range(1, k ? 14 : 12);
                while (text.size() > r)
                    void'(text.pop_back());
                send_text(k ? TAG_GEN : TAG_UTC);
            end
            else
            begin
                // noise with any tag
                repeat ($urandom_range(1, 18))
                    text.push_back(8'($urandom));
                case ($urandom_range(0, 3))
                    0: send_text(TAG_UTC);
                    1: send_text(TAG_GEN);
                    default: send_text(8'($urandom));
                endcase
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_chars.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_times.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d characters sent, %0d results checked (%0d converted, %0d rejected)",
                 chars_sent, times_checked, times_valid, times_invalid);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
